[src/wjp_pkg.sv]
package wjp_pkg;

    localparam int ORDER_W     = 3;
    localparam int WEIGHT_W    = 21;
    localparam int WEIGHT_FRAC = 20;
    localparam int CFG_W       = WEIGHT_W;
    localparam int CFG_IDX_W   = 1;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_ORDER   = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_RELAX_WEIGHT = 1'b1;

    localparam logic [ORDER_W-1:0]  ORDER_RESET  = 3'd6;
    localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = 21'd699051;
    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE   = 21'h100000;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = 2;
    localparam int QUEUE_CNT_W = 3;

    typedef struct packed {
        logic [ORDER_W-1:0]  order;
        logic [WEIGHT_W-1:0] weight;
    } cfg_t;

    typedef struct packed {
        logic has_int;
        logic has_bnd;
        logic done;
    } point_kind_t;

endpackage

[src/weighted_jacobi_poisson_sweep.sv]
// with the queue empty, a result passes the front register, queue and back pipeline; a
// boundary result of the same transfer leaves after its interior result; an interior point
// is caused by the transfer of the point below it, one grid row later; throughput: one
// point in, one result out per cycle unless stalled; on the last row two results per point
// fill the 4-entry queue and stall the input; reset empties the queue and the pipeline and
// sets raster to the origin, grid_order 6, relax_weight 699051; line buffers are not cleared
module weighted_jacobi_poisson_sweep #(
    parameter int MAX_ORDER = 6,
    parameter int DATA_WIDTH = 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [wjp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [wjp_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic signed [DATA_WIDTH-1:0]  v_sample,
    input  logic signed [DATA_WIDTH-1:0]  f_sample,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [DATA_WIDTH-1:0]  v_updated,
    output logic [MAX_ORDER:0]            out_row,
    output logic [MAX_ORDER:0]            out_col,
    output logic                          grid_done
);

    localparam int IDX_W = MAX_ORDER + 1;
    localparam int DW    = DATA_WIDTH;
    localparam int QW    = $bits(wjp_pkg::point_kind_t) + 2 * IDX_W + 6 * DW;

    logic [wjp_pkg::ORDER_W-1:0]  grid_order_reg;
    logic [wjp_pkg::WEIGHT_W-1:0] relax_weight_reg;
    wjp_pkg::cfg_t                cfg;
    logic                         restart;

    logic                            q_push;
    logic                            q_pop;
    logic                            q_not_empty;
    logic [wjp_pkg::QUEUE_CNT_W-1:0] q_count;
    logic [QW-1:0]                   q_wdata;
    logic [QW-1:0]                   q_rdata;

    wjp_pkg::point_kind_t fr_kind, hd_kind;
    logic [IDX_W-1:0]     fr_row, fr_col, hd_row, hd_col;
    logic signed [DW-1:0] fr_up, fr_left, fr_right, fr_down, fr_centre, fr_rhs;
    logic signed [DW-1:0] hd_up, hd_left, hd_right, hd_down, hd_centre, hd_rhs;

    assign restart = cfg_wr_en && (cfg_index == wjp_pkg::REG_GRID_ORDER);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_order_reg   <= wjp_pkg::ORDER_RESET;
            relax_weight_reg <= wjp_pkg::WEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                wjp_pkg::REG_GRID_ORDER:   grid_order_reg   <= cfg_wr_data[wjp_pkg::ORDER_W-1:0];
                wjp_pkg::REG_RELAX_WEIGHT: relax_weight_reg <= cfg_wr_data;
                default:                   relax_weight_reg <= relax_weight_reg;
            endcase
        end
    end

    // order clamped to 1..MAX_ORDER, weight clamped to one
    always_comb
    begin
        cfg.order = grid_order_reg;
        if (grid_order_reg == '0)
        begin
            cfg.order = wjp_pkg::ORDER_W'(1);
        end
        else if (int'(grid_order_reg) > MAX_ORDER)
        begin
            cfg.order = wjp_pkg::ORDER_W'(MAX_ORDER);
        end
        cfg.weight = (relax_weight_reg > wjp_pkg::WEIGHT_ONE) ? wjp_pkg::WEIGHT_ONE
                                                               : relax_weight_reg;
    end

    wjp_front #(.DW(DW), .MAX_ORDER(MAX_ORDER)) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .restart   (restart),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .v_sample  (v_sample),
        .f_sample  (f_sample),
        .q_count   (q_count),
        .push      (q_push),
        .kind      (fr_kind),
        .pt_row    (fr_row),
        .pt_col    (fr_col),
        .nb_up     (fr_up),
        .nb_left   (fr_left),
        .nb_right  (fr_right),
        .nb_down   (fr_down),
        .nb_centre (fr_centre),
        .rhs       (fr_rhs)
    );

    assign q_wdata = {fr_kind, fr_row, fr_col, fr_up, fr_left, fr_right,
                      fr_down, fr_centre, fr_rhs};

    wjp_queue #(.WIDTH(QW)) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .pop       (q_pop),
        .rdata     (q_rdata),
        .not_empty (q_not_empty),
        .count     (q_count)
    );

    assign {hd_kind, hd_row, hd_col, hd_up, hd_left, hd_right,
            hd_down, hd_centre, hd_rhs} = q_rdata;

    wjp_back #(.DW(DW), .MAX_ORDER(MAX_ORDER)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .q_valid   (q_not_empty),
        .q_pop     (q_pop),
        .kind      (hd_kind),
        .pt_row    (hd_row),
        .pt_col    (hd_col),
        .nb_up     (hd_up),
        .nb_left   (hd_left),
        .nb_right  (hd_right),
        .nb_down   (hd_down),
        .nb_centre (hd_centre),
        .rhs       (hd_rhs),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .v_updated (v_updated),
        .out_row   (out_row),
        .out_col   (out_col),
        .grid_done (grid_done)
    );

    // queue never overflows
    a_queue_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && !q_pop && (q_count == wjp_pkg::QUEUE_CNT_W'(wjp_pkg::QUEUE_DEPTH))))
        else $error("queue overflow");

    // no pop from an empty queue
    a_queue_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_pop && !q_not_empty))
        else $error("queue underflow");

    // a full queue holds off the input
    a_full_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        (q_count == wjp_pkg::QUEUE_CNT_W'(wjp_pkg::QUEUE_DEPTH)) |-> in_stall)
        else $error("input open while queue full");

    // the final point sits on the diagonal corner
    a_done_corner: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && grid_done) |-> (out_row == out_col) && (out_row != '0))
        else $error("grid_done off the corner");

endmodule

[src/wjp_ram.sv]
module wjp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[src/wjp_front.sv]
module wjp_front #(
    parameter int DW = 32,
    parameter int MAX_ORDER = 6,
    localparam int IDX_W = MAX_ORDER + 1
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  wjp_pkg::cfg_t                   cfg,
    input  logic                            restart,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic signed [DW-1:0]            v_sample,
    input  logic signed [DW-1:0]            f_sample,
    input  logic [wjp_pkg::QUEUE_CNT_W-1:0] q_count,
    output logic                            push,
    output wjp_pkg::point_kind_t            kind,
    output logic [IDX_W-1:0]                pt_row,
    output logic [IDX_W-1:0]                pt_col,
    output logic signed [DW-1:0]            nb_up,
    output logic signed [DW-1:0]            nb_left,
    output logic signed [DW-1:0]            nb_right,
    output logic signed [DW-1:0]            nb_down,
    output logic signed [DW-1:0]            nb_centre,
    output logic signed [DW-1:0]            rhs
);

    localparam int LINE_LEN = (2 ** MAX_ORDER) + 1;
    localparam int CW = wjp_pkg::QUEUE_CNT_W + 1;

    logic [IDX_W-1:0] last;
    logic             accept;
    logic [IDX_W-1:0] row_reg, row_next;
    logic [IDX_W-1:0] col_reg, col_next;
    logic [IDX_W-1:0] right_addr;
    wjp_pkg::point_kind_t kind_next;

    logic                 f1_valid_reg;
    logic [IDX_W-1:0]     f1_row_reg;
    logic [IDX_W-1:0]     f1_col_reg;
    logic signed [DW-1:0] f1_v_reg;
    wjp_pkg::point_kind_t f1_kind_reg;
    logic signed [DW-1:0] left_reg;

    logic [DW-1:0] centre_rd;
    logic [DW-1:0] right_rd;
    logic [DW-1:0] older_rd;
    logic [DW-1:0] f_rd;

    assign last     = IDX_W'(1) << cfg.order;
    assign in_stall = (CW'(q_count) + CW'(f1_valid_reg)) >= CW'(wjp_pkg::QUEUE_DEPTH);
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        row_next = row_reg;
        col_next = col_reg;
        if (restart)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (col_reg == last)
            begin
                col_next = '0;
                row_next = (row_reg == last) ? '0 : row_reg + IDX_W'(1);
            end
            else
            begin
                col_next = col_reg + IDX_W'(1);
            end
        end
    end

    always_comb
    begin
        kind_next.has_int = (row_reg >= IDX_W'(2)) && (col_reg != '0) && (col_reg != last);
        kind_next.has_bnd = (row_reg == '0) || (row_reg == last)
                         || (col_reg == '0) || (col_reg == last);
        kind_next.done    = (row_reg == last) && (col_reg == last);
    end

    assign right_addr = (col_reg == last) ? col_reg : col_reg + IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            f1_valid_reg <= 1'b0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            f1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            f1_row_reg  <= row_reg;
            f1_col_reg  <= col_reg;
            f1_v_reg    <= v_sample;
            f1_kind_reg <= kind_next;
        end
        if (f1_valid_reg)
        begin
            left_reg <= $signed(centre_rd);
        end
    end

    // two copies of the newest row for the centre and right reads
    wjp_ram #(.WIDTH(DW), .DEPTH(LINE_LEN)) u_newer_c (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (v_sample),
        .raddr (col_reg),
        .rdata (centre_rd)
    );

    wjp_ram #(.WIDTH(DW), .DEPTH(LINE_LEN)) u_newer_r (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (v_sample),
        .raddr (right_addr),
        .rdata (right_rd)
    );

    // older row is filled from the newer row in the cycle after the transfer
    wjp_ram #(.WIDTH(DW), .DEPTH(LINE_LEN)) u_older (
        .clk   (clk),
        .we    (f1_valid_reg),
        .waddr (f1_col_reg),
        .wdata (centre_rd),
        .raddr (col_reg),
        .rdata (older_rd)
    );

    wjp_ram #(.WIDTH(DW), .DEPTH(LINE_LEN)) u_rhs (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (f_sample),
        .raddr (col_reg),
        .rdata (f_rd)
    );

    assign push      = f1_valid_reg && (f1_kind_reg.has_int || f1_kind_reg.has_bnd);
    assign kind      = f1_kind_reg;
    assign pt_row    = f1_row_reg;
    assign pt_col    = f1_col_reg;
    assign nb_up     = $signed(older_rd);
    assign nb_left   = left_reg;
    assign nb_right  = $signed(right_rd);
    assign nb_down   = f1_v_reg;
    assign nb_centre = $signed(centre_rd);
    assign rhs       = $signed(f_rd);

endmodule

[src/wjp_queue.sv]
module wjp_queue #(
    parameter int WIDTH = 32
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  logic [WIDTH-1:0]                wdata,
    input  logic                            pop,
    output logic [WIDTH-1:0]                rdata,
    output logic                            not_empty,
    output logic [wjp_pkg::QUEUE_CNT_W-1:0] count
);

    logic [WIDTH-1:0]                slot_reg [wjp_pkg::QUEUE_DEPTH];
    logic [wjp_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [wjp_pkg::QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [wjp_pkg::QUEUE_CNT_W-1:0] count_reg, count_next;

    always_comb
    begin
        case ({push, pop})
            2'b10:   count_next = count_reg + wjp_pkg::QUEUE_CNT_W'(1);
            2'b01:   count_next = count_reg - wjp_pkg::QUEUE_CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + wjp_pkg::QUEUE_PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + wjp_pkg::QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

    assign rdata     = slot_reg[rd_ptr_reg];
    assign not_empty = count_reg != '0;
    assign count     = count_reg;

endmodule

[src/wjp_back.sv]
module wjp_back #(
    parameter int DW = 32,
    parameter int MAX_ORDER = 6,
    localparam int IDX_W = MAX_ORDER + 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  wjp_pkg::cfg_t        cfg,
    input  logic                 q_valid,
    output logic                 q_pop,
    input  wjp_pkg::point_kind_t kind,
    input  logic [IDX_W-1:0]     pt_row,
    input  logic [IDX_W-1:0]     pt_col,
    input  logic signed [DW-1:0] nb_up,
    input  logic signed [DW-1:0] nb_left,
    input  logic signed [DW-1:0] nb_right,
    input  logic signed [DW-1:0] nb_down,
    input  logic signed [DW-1:0] nb_centre,
    input  logic signed [DW-1:0] rhs,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic signed [DW-1:0] v_updated,
    output logic [IDX_W-1:0]     out_row,
    output logic [IDX_W-1:0]     out_col,
    output logic                 grid_done
);

    localparam int STAGES = 7;
    localparam int LAST   = STAGES - 1;
    localparam int SW     = DW + 2;
    localparam int TW     = DW + 2 * MAX_ORDER + 4;
    localparam int DDW    = DW + 3;
    localparam int PW     = DDW + wjp_pkg::WEIGHT_W + 1;
    localparam int AJW    = PW - wjp_pkg::WEIGHT_FRAC;
    localparam int RW     = AJW + 1;
    localparam logic signed [RW-1:0] SAT_HI = {{(RW-DW+1){1'b0}}, {(DW-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

    logic en;
    logic send_int;
    logic half_reg;

    logic [4:0] sh_scale;
    logic [4:0] sh_round;
    logic [4:0] sh_out;

    logic                 valid_reg [STAGES];
    logic                 int_reg   [STAGES];
    logic [IDX_W-1:0]     row_reg   [STAGES];
    logic [IDX_W-1:0]     col_reg   [STAGES];
    logic                 done_reg  [STAGES];
    logic signed [DW-1:0] ctr_reg   [LAST];

    logic signed [DW:0]    s1_reg, s2_reg;
    logic signed [TW-1:0]  fr0_reg, fr1_reg;
    logic signed [SW-1:0]  sum4_reg;
    logic signed [TW-1:0]  t_reg;
    logic signed [DDW-1:0] d_reg;
    logic signed [PW-1:0]  prod_reg;
    logic signed [AJW-1:0] adj_reg;
    logic signed [DW-1:0]  v_out_reg;

    logic signed [RW-1:0]  res_wide;
    logic signed [DW-1:0]  res_sat;

    assign en       = !(valid_reg[LAST] && out_stall);
    assign send_int = kind.has_int && !half_reg;
    assign q_pop    = en && q_valid && !(send_int && kind.has_bnd);

    assign sh_scale = {1'b0, cfg.order, 1'b0};
    assign sh_round = {1'b0, cfg.order, 1'b1};
    assign sh_out   = sh_scale + 5'd2;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b0;
            for (int i = 0; i < STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            // a point with two results sends the interior one first
            if (q_valid)
            begin
                half_reg <= send_int && kind.has_bnd;
            end
            valid_reg[0] <= q_valid;
            for (int i = 1; i < STAGES; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            int_reg[0]  <= send_int;
            row_reg[0]  <= send_int ? pt_row - IDX_W'(1) : pt_row;
            col_reg[0]  <= pt_col;
            done_reg[0] <= !send_int && kind.done;
            ctr_reg[0]  <= send_int ? nb_centre : nb_down;
            for (int i = 1; i < STAGES; i++)
            begin
                int_reg[i]  <= int_reg[i-1];
                row_reg[i]  <= row_reg[i-1];
                col_reg[i]  <= col_reg[i-1];
                done_reg[i] <= done_reg[i-1];
            end
            for (int i = 1; i < LAST; i++)
            begin
                ctr_reg[i] <= ctr_reg[i-1];
            end

            s1_reg    <= (DW+1)'(nb_left) + (DW+1)'(nb_right);
            s2_reg    <= (DW+1)'(nb_up) + (DW+1)'(nb_down);
            fr0_reg   <= TW'(rhs) + (TW'(1) << sh_round);
            sum4_reg  <= SW'(s1_reg) + SW'(s2_reg);
            fr1_reg   <= fr0_reg;
            t_reg     <= (TW'(sum4_reg) <<< sh_scale) + fr1_reg;
            d_reg     <= DDW'(t_reg >>> sh_out) - DDW'(ctr_reg[2]);
            prod_reg  <= PW'(d_reg) * PW'($signed({1'b0, cfg.weight}));
            adj_reg   <= AJW'((prod_reg + (PW'(1) << (wjp_pkg::WEIGHT_FRAC - 1)))
                              >>> wjp_pkg::WEIGHT_FRAC);
            v_out_reg <= int_reg[LAST-1] ? res_sat : ctr_reg[LAST-1];
        end
    end

    always_comb
    begin
        res_wide = RW'(ctr_reg[LAST-1]) + RW'(adj_reg);
        if (res_wide > SAT_HI)
        begin
            res_sat = SAT_HI[DW-1:0];
        end
        else if (res_wide < SAT_LO)
        begin
            res_sat = SAT_LO[DW-1:0];
        end
        else
        begin
            res_sat = res_wide[DW-1:0];
        end
    end

    assign out_valid = valid_reg[LAST];
    assign v_updated = v_out_reg;
    assign out_row   = row_reg[LAST];
    assign out_col   = col_reg[LAST];
    assign grid_done = done_reg[LAST];

endmodule
